// ----- rtl/mcp_pkg.sv -----
package mcp_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int PIX_BITS = 14;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_LAUNCH,
    ST_ROOT,
    ST_EMIT
  } back_state_t;

endpackage

// ----- rtl/mcp_if.sv -----
interface mcp_cmd_if #(parameter int COORD_BITS = 12);
  logic valid;
  logic ready;
  logic cmd;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] edge_x;
  logic signed [COORD_BITS-1:0] edge_y;

  modport source (output valid, cmd, center_x, center_y, edge_x, edge_y, input ready);
  modport sink (input valid, cmd, center_x, center_y, edge_x, edge_y, output ready);
endinterface

interface mcp_pix_if;
  logic valid;
  logic ready;
  logic signed [13:0] pixel_x;
  logic signed [13:0] pixel_y;
  logic last_of_step;
  logic circle_done;

  modport source (output valid, pixel_x, pixel_y, last_of_step, circle_done, input ready);
  modport sink (input valid, pixel_x, pixel_y, last_of_step, circle_done, output ready);
endinterface

// ----- rtl/mcp_front.sv -----
module mcp_front import mcp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  mcp_cmd_if.sink cmds,
  input  logic full,
  output logic push,
  output logic is_start,
  output logic signed [COORD_BITS-1:0] ctr_x,
  output logic signed [COORD_BITS-1:0] ctr_y,
  output logic signed [COORD_BITS:0] dx,
  output logic signed [COORD_BITS:0] dy
);

  assign cmds.ready = !full;
  assign push = cmds.valid && !full;
  assign is_start = (cmds.cmd == CMD_START);
  assign ctr_x = cmds.center_x;
  assign ctr_y = cmds.center_y;

  // one extra bit so the difference never wraps
  assign dx = (COORD_BITS + 1)'(cmds.edge_x) - (COORD_BITS + 1)'(cmds.center_x);
  assign dy = (COORD_BITS + 1)'(cmds.edge_y) - (COORD_BITS + 1)'(cmds.center_y);

endmodule

// ----- rtl/mcp_fifo.sv -----
module mcp_fifo import mcp_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [WIDTH-1:0] wdata,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

// ----- rtl/mcp_sqrt.sv -----
module mcp_sqrt import mcp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [2*COORD_BITS+1:0] radicand,
  output logic done,
  output logic [COORD_BITS:0] root
);

  localparam int RAD_BITS = 2 * COORD_BITS + 2;
  localparam int ROOT_BITS = COORD_BITS + 1;
  localparam int CNT_BITS = $clog2(ROOT_BITS + 1);

  logic busy;
  logic [CNT_BITS-1:0] cnt;
  logic [RAD_BITS-1:0] rem;
  logic [RAD_BITS-1:0] res;
  logic [RAD_BITS-1:0] one;
  logic [RAD_BITS-1:0] trial;

  assign trial = res + one;
  assign root = res[ROOT_BITS-1:0];

  // one result bit per cycle, restoring method
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CNT_BITS'(ROOT_BITS);
        rem <= radicand;
        res <= '0;
        one <= RAD_BITS'(1) << (RAD_BITS - 2);
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + one;
        end else begin
          res <= res >> 1;
        end
        one <= one >> 2;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/mcp_back.sv -----
module mcp_back import mcp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  logic q_start,
  input  logic signed [COORD_BITS-1:0] q_ctr_x,
  input  logic signed [COORD_BITS-1:0] q_ctr_y,
  input  logic signed [COORD_BITS:0] q_dx,
  input  logic signed [COORD_BITS:0] q_dy,
  mcp_pix_if.source pixels
);

  localparam int RAD_BITS = 2 * COORD_BITS + 2;
  localparam int ROOT_BITS = COORD_BITS + 1;
  localparam int DEC_BITS = COORD_BITS + 4;
  localparam int WIDE = (COORD_BITS + 3 > PIX_BITS) ? COORD_BITS + 3 : PIX_BITS;
  localparam logic signed [DEC_BITS-1:0] DEC_ONE = DEC_BITS'(1);
  localparam logic signed [DEC_BITS-1:0] DEC_THREE = DEC_BITS'(3);
  localparam logic signed [DEC_BITS-1:0] DEC_FIVE = DEC_BITS'(5);

  back_state_t state, state_next;

  logic active;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [COORD_BITS:0] dx_r;
  logic signed [COORD_BITS:0] dy_r;
  logic [RAD_BITS-1:0] dx_sq;
  logic [RAD_BITS-1:0] dy_sq;
  logic signed [RAD_BITS-1:0] dx_prod;
  logic signed [RAD_BITS-1:0] dy_prod;
  logic [ROOT_BITS-1:0] step_x;
  logic [ROOT_BITS-1:0] step_y;
  logic signed [DEC_BITS-1:0] decision;
  logic [2:0] k;

  logic sqrt_start;
  logic sqrt_done;
  logic [ROOT_BITS-1:0] sqrt_root;
  logic load;
  logic done_now;

  logic signed [DEC_BITS-1:0] x_ext;
  logic signed [DEC_BITS-1:0] y_ext;
  logic signed [DEC_BITS-1:0] root_ext;
  logic signed [WIDE-1:0] cx_w, cy_w, x_w, y_w;
  logic signed [WIDE-1:0] px, py;

  mcp_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (dx_sq + dy_sq),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  assign dx_prod = RAD_BITS'(dx_r) * RAD_BITS'(dx_r);
  assign dy_prod = RAD_BITS'(dy_r) * RAD_BITS'(dy_r);
  assign x_ext = DEC_BITS'(step_x);
  assign y_ext = DEC_BITS'(step_y);
  assign root_ext = DEC_BITS'(sqrt_root);
  assign done_now = (step_x >= step_y);
  assign load = (state == ST_EMIT) && (!pixels.valid || pixels.ready);

  assign cx_w = WIDE'(cx);
  assign cy_w = WIDE'(cy);
  assign x_w = WIDE'(step_x);
  assign y_w = WIDE'(step_y);

  // eight octant points in a fixed order
  always_comb begin
    unique case (k)
      3'd0: begin px = cx_w + x_w; py = cy_w + y_w; end
      3'd1: begin px = cx_w + y_w; py = cy_w + x_w; end
      3'd2: begin px = cx_w + y_w; py = cy_w - x_w; end
      3'd3: begin px = cx_w + x_w; py = cy_w - y_w; end
      3'd4: begin px = cx_w - x_w; py = cy_w - y_w; end
      3'd5: begin px = cx_w - y_w; py = cy_w - x_w; end
      3'd6: begin px = cx_w - y_w; py = cy_w + x_w; end
      default: begin px = cx_w - x_w; py = cy_w + y_w; end
    endcase
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    sqrt_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_start) begin
            state_next = ST_SQUARE;
          end else if (active) begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_SQUARE: state_next = ST_LAUNCH;
      ST_LAUNCH: begin
        sqrt_start = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (sqrt_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load && k == 3'd7) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      k <= '0;
      pixels.valid <= 1'b0;
      cx <= '0;
      cy <= '0;
      step_x <= '0;
      step_y <= '0;
      decision <= '0;
    end else begin
      if (load) begin
        pixels.valid <= 1'b1;
      end else if (pixels.ready) begin
        pixels.valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_start) begin
              cx <= q_ctr_x;
              cy <= q_ctr_y;
              dx_r <= q_dx;
              dy_r <= q_dy;
            end else if (active) begin
              if (decision[DEC_BITS-1]) begin
                decision <= decision + (x_ext <<< 1) + DEC_THREE;
              end else begin
                decision <= decision + ((x_ext - y_ext) <<< 1) + DEC_FIVE;
                step_y <= step_y - 1'b1;
              end
              step_x <= step_x + 1'b1;
            end
          end
          k <= '0;
        end
        ST_SQUARE: begin
          dx_sq <= $unsigned(dx_prod);
          dy_sq <= $unsigned(dy_prod);
        end
        ST_LAUNCH: ;
        ST_ROOT: begin
          if (sqrt_done) begin
            step_x <= '0;
            step_y <= sqrt_root;
            decision <= DEC_ONE - root_ext;
          end
        end
        ST_EMIT: begin
          if (load) begin
            k <= k + 1'b1;
            if (k == 3'd7) begin
              active <= !done_now;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixels.pixel_x <= px[PIX_BITS-1:0];
      pixels.pixel_y <= py[PIX_BITS-1:0];
      pixels.last_of_step <= (k == 3'd7);
      pixels.circle_done <= done_now;
    end
  end

endmodule

// ----- rtl/midpoint_circle_pixels.sv -----
// midpoint circle rasteriser with eight-way symmetry
// cmds channel: cmd start (centre plus a point on the circle) or advance
// pixels channel: eight pixels per emitting transaction, last_of_step on the
//   eighth, circle_done on all eight of the step that reaches x >= y
// a two-entry queue sits between the command front and the drawing back end,
// so commands are taken while pixels are still being drawn
// a start runs the squaring and then the bit-serial square root (one root bit
//   per cycle, COORD_BITS + 1 bits) before its first pixel, then emits eight
//   pixels at one per cycle while the receiver is ready
// an advance pops and updates the decision term, then sends its eight pixels
//   through the output register
// an advance with no circle in progress is dropped without output
// reset clears the queue, the output valid flag and the circle state
// when the receiver stalls the output register holds its pixel, the back end
//   waits, and once the queue fills cmds.ready drops
module midpoint_circle_pixels import mcp_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input logic clk,
  input logic rst,
  mcp_cmd_if.sink cmds,
  mcp_pix_if.source pixels
);

  localparam int QW = 1 + 2 * COORD_BITS + 2 * (COORD_BITS + 1);

  logic full;
  logic push;
  logic is_start;
  logic signed [COORD_BITS-1:0] ctr_x, ctr_y;
  logic signed [COORD_BITS:0] dx, dy;

  logic q_valid;
  logic q_pop;
  logic [QW-1:0] q_data;
  logic q_start;
  logic signed [COORD_BITS-1:0] q_ctr_x, q_ctr_y;
  logic signed [COORD_BITS:0] q_dx, q_dy;

  mcp_front #(.COORD_BITS(COORD_BITS)) u_front (
    .cmds     (cmds),
    .full     (full),
    .push     (push),
    .is_start (is_start),
    .ctr_x    (ctr_x),
    .ctr_y    (ctr_y),
    .dx       (dx),
    .dy       (dy)
  );

  mcp_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     ({is_start, ctr_x, ctr_y, dx, dy}),
    .full      (full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rdata     (q_data)
  );

  assign {q_start, q_ctr_x, q_ctr_y, q_dx, q_dy} = q_data;

  mcp_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_start (q_start),
    .q_ctr_x (q_ctr_x),
    .q_ctr_y (q_ctr_y),
    .q_dx    (q_dx),
    .q_dy    (q_dy),
    .pixels  (pixels)
  );

endmodule
